/* design/hbs_pkg.sv */
`timescale 1ns / 1ps
package hbs_pkg;

  // default grid bound and reset values of the configuration registers
  localparam int MAX_DIM_DEF = 64;
  localparam logic [6:0]  COLS_RST = 7'd64;
  localparam logic [6:0]  ROWS_RST = 7'd64;
  localparam logic [15:0] CELL_RST = 16'd256;

  // datapath widths
  localparam int IDX_W  = 8;   // cell index, enough for the largest grid bound
  localparam int C_W    = 17;  // doubled cell size and remainders
  localparam int C2_W   = 34;  // square of the doubled cell size
  localparam int SPAN_W = 23;  // cell size times cells per axis
  localparam int OFF_W  = 26;  // doubled offset from the grid corner, signed
  localparam int AB_W   = 35;  // one row of the interpolation, signed
  localparam int PH_W   = 36;  // high partial product, signed
  localparam int ACC_W  = 52;  // full interpolation sum and its biased form
  localparam int HQ_W   = 16;  // height quotient bits
  localparam int BASE_W = 16;  // linear store address before truncation

  // result queue depth, covers the back pipeline in flight
  localparam int OUT_DEPTH = 26;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_COLS = 2'd0,
    REG_ROWS = 2'd1,
    REG_CELL = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    op_t                operation;
    logic [11:0]        load_index;
    logic signed [15:0] load_value;
    logic signed [23:0] query_x;
    logic signed [23:0] query_y;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sampled_height;
    logic               cell_flat;
    logic               edge_axis;
    logic               outside_grid;
  } out_item_t;

  // grid setup derived from the configuration registers
  typedef struct packed {
    logic [6:0]        cols;
    logic [C_W-1:0]    c;
    logic [C2_W-1:0]   c2;
    logic [SPAN_W-1:0] span_x;
    logic [SPAN_W-1:0] span_y;
    logic              bad;
  } cfg_t;

  // classified item between the front and the back
  typedef struct packed {
    op_t                operation;
    logic               outside;
    logic [11:0]        load_index;
    logic signed [15:0] load_value;
    logic [IDX_W-1:0]   xi;
    logic [IDX_W-1:0]   yi;
    logic [C_W-1:0]     rx;
    logic [C_W-1:0]     ry;
  } mid_item_t;

endpackage

/* design/heightmap_bilinear_sampler.sv */
`timescale 1ns / 1ps
// throughput: one transaction per cycle while full is low and the result queue is drained,
// set by the bit-per-stage quotient pipelines and by four copies of the height store that
// give all corners in the same read
// reset: rst_n synchronous active low, clears queues, pipeline valids, loads register
// defaults (64 columns, 64 rows, cell size 256); the height store is not cleared
module heightmap_bilinear_sampler
  import hbs_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_data,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int QW        = $clog2(MAX_DIM);
  localparam int MID_DEPTH = QW + 4;
  localparam int MID_CW    = $clog2(MID_DEPTH+1);
  localparam int OUT_CW    = $clog2(OUT_DEPTH+1);

  logic [6:0]          cols_r, rows_r;
  logic [15:0]         cell_r;
  cfg_t                cfg_nxt, cfg_r;

  logic                in_acc;
  logic                mid_push, back_pop, res_valid, out_pop;
  mid_item_t           mid_item, mid_head;
  logic [$bits(mid_item_t)-1:0] mid_bits;
  logic [MID_CW-1:0]   mid_count;
  logic [MID_CW-1:0]   front_cnt_r, front_cnt_nxt;
  out_item_t           res_item;
  logic [$bits(out_item_t)-1:0] out_bits;
  logic [OUT_CW-1:0]   out_count;
  logic [OUT_CW-1:0]   out_cred_r, out_cred_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_RST;
      rows_r <= ROWS_RST;
      cell_r <= CELL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLS: cols_r <= cfg_data[6:0];
        REG_ROWS: rows_r <= cfg_data[6:0];
        REG_CELL: cell_r <= cfg_data;
        default:  ;
      endcase
    end
  end

  // grid setup derived once from the registers
  always_comb begin
    cfg_nxt.cols   = cols_r;
    cfg_nxt.c      = {cell_r, 1'b0};
    cfg_nxt.c2     = C2_W'(cfg_nxt.c) * C2_W'(cfg_nxt.c);
    cfg_nxt.span_x = SPAN_W'(cell_r) * SPAN_W'(cols_r - 7'd1);
    cfg_nxt.span_y = SPAN_W'(cell_r) * SPAN_W'(rows_r - 7'd1);
    cfg_nxt.bad    = (cols_r < 7'd2) || (32'(cols_r) > MAX_DIM) ||
                     (rows_r < 7'd2) || (32'(rows_r) > MAX_DIM) ||
                     (cell_r == 16'd0);
  end

  always_ff @(posedge clk) begin
    cfg_r <= cfg_nxt;
  end

  // input side: credits cover the front pipeline and the middle queue
  assign full   = !rst_n || (front_cnt_r >= MID_CW'(MID_DEPTH));
  assign in_acc = push && !full;

  hbs_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_acc),
    .in_item  (in_data),
    .cfg      (cfg_r),
    .mid_valid(mid_push),
    .mid_item (mid_item)
  );

  hbs_queue #(.DEPTH(MID_DEPTH), .WIDTH($bits(mid_item_t))) u_mid_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (mid_push),
    .wr_data(mid_item),
    .rd_en  (back_pop),
    .rd_data(mid_bits),
    .count  (mid_count)
  );

  assign mid_head = mid_item_t'(mid_bits);

  // back side: credits cover the back pipeline and the result queue
  assign back_pop = (mid_count != '0) && (out_cred_r < OUT_CW'(OUT_DEPTH));
  assign out_pop  = pop && !empty;

  always_comb begin
    front_cnt_nxt = front_cnt_r + MID_CW'(in_acc) - MID_CW'(back_pop);
    out_cred_nxt  = out_cred_r + OUT_CW'(back_pop && (mid_head.operation == OP_QUERY)) -
                    OUT_CW'(out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_cnt_r <= '0;
      out_cred_r  <= '0;
    end else begin
      front_cnt_r <= front_cnt_nxt;
      out_cred_r  <= out_cred_nxt;
    end
  end

  hbs_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (back_pop),
    .in_item  (mid_head),
    .cfg      (cfg_r),
    .res_valid(res_valid),
    .res_item (res_item)
  );

  hbs_queue #(.DEPTH(OUT_DEPTH), .WIDTH($bits(out_item_t))) u_out_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (res_valid),
    .wr_data(res_item),
    .rd_en  (out_pop),
    .rd_data(out_bits),
    .count  (out_count)
  );

  assign out_data = out_item_t'(out_bits);
  assign empty    = !rst_n || (out_count == '0);

`ifndef SYNTH
  // the front never holds more transactions than its credits allow
  a_front_credit: assert property (@(posedge clk) disable iff (!rst_n)
    front_cnt_r <= MID_CW'(MID_DEPTH))
    else $error("front credit count above middle queue depth");

  // a classified transaction always finds room in the middle queue
  a_mid_room: assert property (@(posedge clk) disable iff (!rst_n)
    mid_push |-> (mid_count < MID_CW'(MID_DEPTH)))
    else $error("middle queue overflow");

  // a finished result always finds room in the result queue
  a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (out_count < OUT_CW'(OUT_DEPTH)))
    else $error("result queue overflow");

  // queued results are all covered by outstanding credits
  a_out_cover: assert property (@(posedge clk) disable iff (!rst_n)
    out_count <= out_cred_r)
    else $error("result queue holds more than its credits");
`endif

endmodule

/* design/hbs_queue.sv */
`timescale 1ns / 1ps
module hbs_queue
  import hbs_pkg::*;
#(
  parameter int DEPTH = OUT_DEPTH,
  parameter int WIDTH = $bits(out_item_t)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    head_r, head_nxt;
  logic [PW-1:0]    tail_r, tail_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  // pointer and fill bookkeeping
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r + CW'(wr_en) - CW'(rd_en);
    if (rd_en) begin
      head_nxt = (head_r == PW'(DEPTH-1)) ? '0 : head_r + 1'b1;
    end
    if (wr_en) begin
      tail_nxt = (tail_r == PW'(DEPTH-1)) ? '0 : tail_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[tail_r] <= wr_data;
    end
  end

  assign rd_data = slot_r[head_r];
  assign count   = count_r;

endmodule

/* design/hbs_front.sv */
`timescale 1ns / 1ps
module hbs_front
  import hbs_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_item_t  in_item,
  input  cfg_t      cfg,
  output logic      mid_valid,
  output mid_item_t mid_item
);

  localparam int QW = $clog2(MAX_DIM);

  typedef struct packed {
    logic               valid;
    op_t                operation;
    logic               outside;
    logic [11:0]        load_index;
    logic signed [15:0] load_value;
    logic [OFF_W-1:0]   remx;
    logic [OFF_W-1:0]   remy;
    logic [IDX_W-1:0]   qx;
    logic [IDX_W-1:0]   qy;
  } div_t;

  logic                    a_valid_r;
  in_item_t                a_item_r;
  logic signed [OFF_W-1:0] offx, offy;
  logic                    outx, outy;
  div_t                    d0;
  div_t                    div_r [QW+1];

  // one quotient bit per axis: subtract the shifted cell width if it fits
  function automatic div_t div_step(input div_t d, input int k, input logic [C_W-1:0] c);
    div_t             r;
    logic [OFF_W-1:0] dv;
    r  = d;
    dv = OFF_W'(c) << k;
    if (d.remx >= dv) begin
      r.remx = d.remx - dv;
      r.qx   = d.qx | (IDX_W'(1) << k);
    end
    if (d.remy >= dv) begin
      r.remy = d.remy - dv;
      r.qy   = d.qy | (IDX_W'(1) << k);
    end
    return r;
  endfunction

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
    end
    a_item_r <= in_item;
  end

  // doubled offsets from the grid corner and range check
  assign offx = (OFF_W'(a_item_r.query_x) <<< 1) + $signed(OFF_W'(cfg.span_x));
  assign offy = (OFF_W'(a_item_r.query_y) <<< 1) + $signed(OFF_W'(cfg.span_y));
  assign outx = offx[OFF_W-1] || ($unsigned(offx) >= OFF_W'({cfg.span_x, 1'b0}));
  assign outy = offy[OFF_W-1] || ($unsigned(offy) >= OFF_W'({cfg.span_y, 1'b0}));

  always_comb begin
    d0.valid      = a_valid_r;
    d0.operation  = a_item_r.operation;
    d0.outside    = cfg.bad || outx || outy;
    d0.load_index = a_item_r.load_index;
    d0.load_value = a_item_r.load_value;
    d0.remx       = $unsigned(offx);
    d0.remy       = $unsigned(offy);
    d0.qx         = '0;
    d0.qy         = '0;
  end

  // quotient pipeline, most significant bit first
  always_ff @(posedge clk) begin
    div_r[0] <= d0;
    for (int s = 0; s < QW; s++) begin
      div_r[s+1] <= div_step(div_r[s], QW-1-s, cfg.c);
    end
    if (!rst_n) begin
      for (int s = 0; s <= QW; s++) begin
        div_r[s].valid <= 1'b0;
      end
    end
  end

  // classified item toward the back
  assign mid_valid = div_r[QW].valid;
  always_comb begin
    mid_item.operation  = div_r[QW].operation;
    mid_item.outside    = div_r[QW].outside;
    mid_item.load_index = div_r[QW].load_index;
    mid_item.load_value = div_r[QW].load_value;
    mid_item.xi         = div_r[QW].qx;
    mid_item.yi         = div_r[QW].qy;
    mid_item.rx         = div_r[QW].remx[C_W-1:0];
    mid_item.ry         = div_r[QW].remy[C_W-1:0];
  end

endmodule

/* design/hbs_back.sv */
`timescale 1ns / 1ps
module hbs_back
  import hbs_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  mid_item_t in_item,
  input  cfg_t      cfg,
  output logic      res_valid,
  output out_item_t res_item
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  typedef struct packed {
    logic               valid;
    logic               is_query;
    logic               outside;
    logic               we;
    logic [BASE_W-1:0]  base;
    logic signed [15:0] wdata;
    logic [C_W-1:0]     wx0, wx1, wy0, wy1;
    logic               axis;
  } b1_t;

  typedef struct packed {
    logic           valid;
    logic           is_query;
    logic           outside;
    logic [C_W-1:0] wx0, wx1, wy0, wy1;
    logic           axis;
  } b2_t;

  typedef struct packed {
    logic                  valid;
    logic                  is_query;
    logic                  outside;
    logic                  flat;
    logic                  axis;
    logic signed [AB_W-1:0] a;
    logic signed [AB_W-1:0] b;
    logic [C_W-1:0]        wy0, wy1;
  } b3_t;

  typedef struct packed {
    logic                   valid;
    logic                   is_query;
    logic                   outside;
    logic                   flat;
    logic                   axis;
    logic signed [PH_W-1:0] pa_hi, pb_hi;
    logic [C2_W-1:0]        pa_lo, pb_lo;
  } b4_t;

  typedef struct packed {
    logic                    valid;
    logic                    is_query;
    logic                    outside;
    logic                    flat;
    logic                    axis;
    logic signed [ACC_W-1:0] num;
  } b5_t;

  typedef struct packed {
    logic             valid;
    logic             is_query;
    logic             outside;
    logic             flat;
    logic             axis;
    logic [ACC_W-1:0] rem;
    logic [HQ_W-1:0]  q;
  } dv_t;

  logic               b0_valid_r;
  mid_item_t          b0_item_r;
  b1_t                b1_nxt, b1_r;
  b2_t                b2_r;
  b3_t                b3_nxt, b3_r;
  b4_t                b4_nxt, b4_r;
  b5_t                b5_nxt, b5_r;
  dv_t                dv0;
  dv_t                dv_r [HQ_W+1];

  logic [C_W-1:0]     dx1, dy1, dx2, dy2, dmin;
  logic [AW-1:0]      a00, a01, a10, a11;
  logic signed [15:0] mem00 [DEPTH];
  logic signed [15:0] mem01 [DEPTH];
  logic signed [15:0] mem10 [DEPTH];
  logic signed [15:0] mem11 [DEPTH];
  logic signed [15:0] h00_r, h01_r, h10_r, h11_r;
  logic signed [17:0] swx0, swx1, swy0, swy1;
  logic signed [17:0] a_hi, b_hi;
  logic [C_W-1:0]     a_lo, b_lo;
  logic [HQ_W-1:0]    qf;

  // one quotient bit of the height division
  function automatic dv_t dv_step(input dv_t d, input int k, input logic [C2_W-1:0] c2);
    dv_t              r;
    logic [ACC_W-1:0] dv;
    r  = d;
    dv = ACC_W'(c2) << k;
    if (d.rem >= dv) begin
      r.rem = d.rem - dv;
      r.q   = d.q | (HQ_W'(1) << k);
    end
    return r;
  endfunction

  // entry register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_valid_r <= 1'b0;
    end else begin
      b0_valid_r <= in_valid;
    end
    b0_item_r <= in_item;
  end

  // nearest cell edge
  always_comb begin
    dx1  = b0_item_r.rx;
    dy1  = b0_item_r.ry;
    dx2  = cfg.c - b0_item_r.rx;
    dy2  = cfg.c - b0_item_r.ry;
    dmin = (dx1 <= dy1) ? dx1 : dy1;
    if (dx2 <= dmin) begin
      dmin = dx2;
    end
  end

  // store address, write decode and corner weights
  always_comb begin
    b1_nxt.valid    = b0_valid_r;
    b1_nxt.is_query = (b0_item_r.operation == OP_QUERY);
    b1_nxt.outside  = b0_item_r.outside;
    b1_nxt.we       = b0_valid_r && (b0_item_r.operation == OP_LOAD) &&
                      (32'(b0_item_r.load_index) < DEPTH);
    if (b0_item_r.operation == OP_LOAD) begin
      b1_nxt.base = BASE_W'(b0_item_r.load_index);
    end else begin
      b1_nxt.base = BASE_W'(b0_item_r.yi) * BASE_W'(cfg.cols) + BASE_W'(b0_item_r.xi);
    end
    b1_nxt.wdata = b0_item_r.load_value;
    b1_nxt.wx0   = dx2;
    b1_nxt.wx1   = dx1;
    b1_nxt.wy0   = dy2;
    b1_nxt.wy1   = dy1;
    if (dy2 <= dmin) begin
      b1_nxt.axis = 1'b1;
    end else if (dx1 <= dmin) begin
      b1_nxt.axis = 1'b0;
    end else if (dy1 <= dmin) begin
      b1_nxt.axis = 1'b1;
    end else begin
      b1_nxt.axis = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    b1_r <= b1_nxt;
    if (!rst_n) begin
      b1_r.valid <= 1'b0;
    end
  end

  // four copies of the height store, one read port per corner
  assign a00 = b1_r.base[AW-1:0];
  assign a01 = AW'(b1_r.base + BASE_W'(1));
  assign a10 = AW'(b1_r.base + BASE_W'(cfg.cols));
  assign a11 = AW'(b1_r.base + BASE_W'(cfg.cols) + BASE_W'(1));

  always_ff @(posedge clk) begin
    if (b1_r.valid && b1_r.we) begin
      mem00[a00] <= b1_r.wdata;
      mem01[a00] <= b1_r.wdata;
      mem10[a00] <= b1_r.wdata;
      mem11[a00] <= b1_r.wdata;
    end
    h00_r <= mem00[a00];
    h01_r <= mem01[a01];
    h10_r <= mem10[a10];
    h11_r <= mem11[a11];
  end

  always_ff @(posedge clk) begin
    b2_r.is_query <= b1_r.is_query;
    b2_r.outside  <= b1_r.outside;
    b2_r.wx0      <= b1_r.wx0;
    b2_r.wx1      <= b1_r.wx1;
    b2_r.wy0      <= b1_r.wy0;
    b2_r.wy1      <= b1_r.wy1;
    b2_r.axis     <= b1_r.axis;
    if (!rst_n) begin
      b2_r.valid <= 1'b0;
    end else begin
      b2_r.valid <= b1_r.valid;
    end
  end

  // blend along x for the lower and upper rows
  assign swx0 = $signed({1'b0, b2_r.wx0});
  assign swx1 = $signed({1'b0, b2_r.wx1});

  always_comb begin
    b3_nxt.valid    = b2_r.valid;
    b3_nxt.is_query = b2_r.is_query;
    b3_nxt.outside  = b2_r.outside;
    b3_nxt.axis     = b2_r.axis;
    b3_nxt.flat     = (h00_r == h01_r) && (h00_r == h10_r) && (h00_r == h11_r);
    b3_nxt.a        = AB_W'(h00_r) * AB_W'(swx0) + AB_W'(h01_r) * AB_W'(swx1);
    b3_nxt.b        = AB_W'(h10_r) * AB_W'(swx0) + AB_W'(h11_r) * AB_W'(swx1);
    b3_nxt.wy0      = b2_r.wy0;
    b3_nxt.wy1      = b2_r.wy1;
  end

  always_ff @(posedge clk) begin
    b3_r <= b3_nxt;
    if (!rst_n) begin
      b3_r.valid <= 1'b0;
    end
  end

  // blend along y, split into high and low partial products
  assign swy0 = $signed({1'b0, b3_r.wy0});
  assign swy1 = $signed({1'b0, b3_r.wy1});
  assign a_hi = b3_r.a[AB_W-1:C_W];
  assign b_hi = b3_r.b[AB_W-1:C_W];
  assign a_lo = b3_r.a[C_W-1:0];
  assign b_lo = b3_r.b[C_W-1:0];

  always_comb begin
    b4_nxt.valid    = b3_r.valid;
    b4_nxt.is_query = b3_r.is_query;
    b4_nxt.outside  = b3_r.outside;
    b4_nxt.flat     = b3_r.flat;
    b4_nxt.axis     = b3_r.axis;
    b4_nxt.pa_hi    = PH_W'(a_hi) * PH_W'(swy0);
    b4_nxt.pb_hi    = PH_W'(b_hi) * PH_W'(swy1);
    b4_nxt.pa_lo    = C2_W'(a_lo) * C2_W'(b3_r.wy0);
    b4_nxt.pb_lo    = C2_W'(b_lo) * C2_W'(b3_r.wy1);
  end

  always_ff @(posedge clk) begin
    b4_r <= b4_nxt;
    if (!rst_n) begin
      b4_r.valid <= 1'b0;
    end
  end

  // full weighted sum
  always_comb begin
    b5_nxt.valid    = b4_r.valid;
    b5_nxt.is_query = b4_r.is_query;
    b5_nxt.outside  = b4_r.outside;
    b5_nxt.flat     = b4_r.flat;
    b5_nxt.axis     = b4_r.axis;
    b5_nxt.num      = (ACC_W'(b4_r.pa_hi) <<< C_W) + $signed(ACC_W'(b4_r.pa_lo)) +
                      (ACC_W'(b4_r.pb_hi) <<< C_W) + $signed(ACC_W'(b4_r.pb_lo));
  end

  always_ff @(posedge clk) begin
    b5_r <= b5_nxt;
    if (!rst_n) begin
      b5_r.valid <= 1'b0;
    end
  end

  // bias to a non-negative dividend with round half up
  always_comb begin
    dv0.valid    = b5_r.valid;
    dv0.is_query = b5_r.is_query;
    dv0.outside  = b5_r.outside;
    dv0.flat     = b5_r.flat;
    dv0.axis     = b5_r.axis;
    dv0.rem      = $unsigned(b5_r.num) + (ACC_W'(cfg.c2) << (HQ_W-1)) +
                   ACC_W'(cfg.c2 >> 1);
    dv0.q        = '0;
  end

  // height division pipeline, one quotient bit per stage
  always_ff @(posedge clk) begin
    dv_r[0] <= dv0;
    for (int s = 0; s < HQ_W; s++) begin
      dv_r[s+1] <= dv_step(dv_r[s], HQ_W-1-s, cfg.c2);
    end
    if (!rst_n) begin
      for (int s = 0; s <= HQ_W; s++) begin
        dv_r[s].valid <= 1'b0;
      end
    end
  end

  // result, bias removed by flipping the top quotient bit
  assign qf        = dv_r[HQ_W].q;
  assign res_valid = dv_r[HQ_W].valid && dv_r[HQ_W].is_query;

  always_comb begin
    if (dv_r[HQ_W].outside) begin
      res_item.sampled_height = '0;
      res_item.cell_flat      = 1'b0;
      res_item.edge_axis      = 1'b0;
      res_item.outside_grid   = 1'b1;
    end else begin
      res_item.sampled_height = $signed({~qf[HQ_W-1], qf[HQ_W-2:0]});
      res_item.cell_flat      = dv_r[HQ_W].flat;
      res_item.edge_axis      = dv_r[HQ_W].axis;
      res_item.outside_grid   = 1'b0;
    end
  end

endmodule
